// ===== rtl/sssp_pkg.sv =====
// Package: shared constants and types of the shortest-path block.
package sssp_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int COST_BITS_DEF = 16;

    localparam int VTX_W      = 6;
    localparam int COST_W     = 16;
    localparam int NODE_CNT_W = 7;
    localparam int DIST_W     = 22;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [DIST_W-1:0] UNREACHABLE = 22'h200000;

    localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

    localparam logic FUNC_ADD_EDGE = 1'b0;
    localparam logic FUNC_SOLVE    = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_RELAX,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } t_state;

    typedef struct packed {
        logic              fin;
        logic [DIST_W-1:0] path_len;
    } t_dist_entry;

endpackage

// ===== rtl/sssp_ram.sv =====
// Generic single-port-write, registered-read RAM (read returns old data on collision).
module sssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/single_source_shortest_path.sv =====
// Top level: dense-graph Dijkstra with edge store and distance table in RAM.
// Edge transfers are taken every cycle, back to back, while the block is idle; a solve
// emits its results, subject to output stalls, then runs a clearing pass over the
// edge store before new input is taken.
// Reset is synchronous, active low; it starts the same clearing pass, during
// which input is stalled (configuration writes are still taken).
module single_source_shortest_path #(
    parameter int MAX_NODES = sssp_pkg::MAX_NODES_DEF,
    parameter int COST_BITS = sssp_pkg::COST_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [sssp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sssp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_func,
    input  logic [sssp_pkg::VTX_W-1:0]        i_from_vertex,
    input  logic [sssp_pkg::VTX_W-1:0]        i_to_vertex,
    input  logic [sssp_pkg::COST_W-1:0]       i_edge_cost,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sssp_pkg::VTX_W-1:0]        o_vertex,
    output logic [sssp_pkg::DIST_W-1:0]       o_distance,
    output logic                              o_last
);

    // Widths derived from the parameters.
    localparam int VW     = $clog2(MAX_NODES);       // vertex index
    localparam int CW     = $clog2(MAX_NODES + 1);   // vertex count
    localparam int EDEPTH = MAX_NODES * MAX_NODES;   // adjacency entries
    localparam int EAW    = $clog2(EDEPTH);
    localparam int EW     = COST_BITS + 1;           // {exists, weight}
    localparam int DW     = $bits(sssp_pkg::t_dist_entry);
    localparam int NW     = sssp_pkg::NODE_CNT_W;
    localparam int DSW    = sssp_pkg::DIST_W;
    localparam int VTX_W_M1 = sssp_pkg::VTX_W - 1;

    // Configuration registers.
    logic [NW-1:0]                  r_node_count;
    logic [sssp_pkg::VTX_W-1:0]     r_source_vertex;

    // Control state.
    sssp_pkg::t_state               r_state, n_state;
    logic [CW-1:0]                  r_idx, n_idx;    // sweep counter over vertices
    logic [EAW-1:0]                 r_clr;           // clearing-pass address
    logic [MAX_NODES-1:0]           r_dvalid;        // distance entry written since clear

    // Sweep pipeline: read issued last cycle, data now on the RAM outputs.
    logic                           r_p_vld;
    logic [VW-1:0]                  r_p_idx;
    logic                           r_p_dv;

    // Round bookkeeping.
    logic [DSW-1:0]                 r_best;
    logic [VW-1:0]                  r_u;
    logic                           r_found;

    // Edge insert pipeline and one-deep write forwarding.
    logic                           r_e_vld;
    logic [EAW-1:0]                 r_e_addr;
    logic [COST_BITS-1:0]           r_e_cost;
    logic                           r_f_vld;
    logic [EAW-1:0]                 r_f_addr;
    logic [EW-1:0]                  r_f_data;

    // Output register.
    logic                           r_o_valid;
    logic [sssp_pkg::VTX_W-1:0]     r_o_vertex;
    logic [DSW-1:0]                 r_o_dist;
    logic                           r_o_last;

    // RAM ports.
    logic                           edge_we;
    logic [EAW-1:0]                 edge_waddr;
    logic [EW-1:0]                  edge_wdata;
    logic [EAW-1:0]                 edge_raddr;
    logic [EW-1:0]                  edge_q;
    logic                           dist_we;
    logic [VW-1:0]                  dist_waddr;
    sssp_pkg::t_dist_entry          dist_wdata;
    logic [DW-1:0]                  dist_q_raw;
    sssp_pkg::t_dist_entry          dist_q;

    // Combinational helpers.
    logic [CW-1:0]                  n_eff;
    logic                           in_xfer;
    logic                           issue;
    logic                           sweep_done;
    logic                           src_in_range;
    logic                           edge_ok;
    logic [EAW-1:0]                 add_addr;
    logic [EAW-1:0]                 relax_addr;
    sssp_pkg::t_dist_entry          d_cur;
    logic [EW-1:0]                  e_cur;
    logic                           e_wr;
    logic [DSW:0]                   sum_raw;
    logic [DSW-1:0]                 sum_sat;
    logic                           rel_self;
    logic                           rel_wr;
    logic                           scan_take;
    logic                           out_xfer;

    sssp_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_q)
    );

    sssp_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (r_idx[VW-1:0]),
        .o_rdata (dist_q_raw)
    );

    assign dist_q = sssp_pkg::t_dist_entry'(dist_q_raw);

    // Node counts above the store size act as the store size.
    assign n_eff = (r_node_count > NW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(r_node_count);

    assign o_in_stall   = (r_state != sssp_pkg::ST_IDLE);
    assign in_xfer      = i_in_valid && !o_in_stall;
    assign out_xfer     = r_o_valid && !i_out_stall;
    assign issue        = (r_idx != n_eff);
    assign sweep_done   = !issue && !r_p_vld;
    assign src_in_range = ({1'b0, r_source_vertex} < NW'(n_eff));

    // Edges with an endpoint outside the store are dropped.
    assign edge_ok  = ({1'b0, i_from_vertex} < NW'(MAX_NODES)) &&
                      ({1'b0, i_to_vertex} < NW'(MAX_NODES));
    assign add_addr = EAW'(EAW'(i_from_vertex[VW-1:0]) * EAW'(MAX_NODES))
                    + EAW'(i_to_vertex[VW-1:0]);
    assign relax_addr = EAW'(EAW'(r_u) * EAW'(MAX_NODES)) + EAW'(r_idx[VW-1:0]);

    // Entries not written since the last clear read as unreached, unfinished.
    always_comb begin
        if (r_p_dv) begin
            d_cur = dist_q;
        end else begin
            d_cur.fin      = 1'b0;
            d_cur.path_len = sssp_pkg::UNREACHABLE;
        end
    end

    // Edge insert: take the write of the previous cycle if it hit the same entry,
    // since the RAM returned the old contents then. Keep the smaller weight.
    assign e_cur = (r_f_vld && (r_f_addr == r_e_addr)) ? r_f_data : edge_q;
    assign e_wr  = r_e_vld && (!e_cur[COST_BITS] || (r_e_cost < e_cur[COST_BITS-1:0]));

    // Relaxation: saturate the path sum at the unreachable mark.
    assign sum_raw  = {1'b0, r_best} + (DSW + 1)'(edge_q[COST_BITS-1:0]);
    assign sum_sat  = (sum_raw > {1'b0, sssp_pkg::UNREACHABLE}) ?
                      sssp_pkg::UNREACHABLE : sum_raw[DSW-1:0];
    assign rel_self = (r_p_idx == r_u);
    assign rel_wr   = (r_state == sssp_pkg::ST_RELAX) && r_p_vld &&
                      (rel_self || (!d_cur.fin && edge_q[COST_BITS] &&
                                    (sum_sat < d_cur.path_len)));

    // Scan: strict less-than in ascending order keeps the lowest index on a tie.
    assign scan_take = (r_state == sssp_pkg::ST_SCAN) && r_p_vld &&
                       !d_cur.fin && (d_cur.path_len < r_best);

    // Next state, sweep counter and RAM controls.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        edge_raddr = relax_addr;
        edge_we    = 1'b0;
        edge_waddr = r_e_addr;
        edge_wdata = {1'b1, r_e_cost};
        dist_we    = 1'b0;
        dist_waddr = r_p_idx;
        dist_wdata = '{fin: 1'b0, path_len: sum_sat};

        // Insert write-back; never overlaps the clearing pass.
        if (e_wr) begin
            edge_we = 1'b1;
        end else if (r_state == sssp_pkg::ST_CLEAR) begin
            edge_we    = 1'b1;
            edge_waddr = r_clr;
            edge_wdata = '0;
        end

        if (rel_wr) begin
            dist_we = 1'b1;
            if (rel_self) begin
                dist_wdata = '{fin: 1'b1, path_len: r_best};
            end
        end

        unique case (r_state)
            sssp_pkg::ST_CLEAR: begin
                if (r_clr == EAW'(EDEPTH - 1)) begin
                    n_state = sssp_pkg::ST_IDLE;
                end
            end
            sssp_pkg::ST_IDLE: begin
                edge_raddr = add_addr;
                if (in_xfer && (i_func == sssp_pkg::FUNC_SOLVE)) begin
                    n_state = sssp_pkg::ST_INIT;
                end
            end
            sssp_pkg::ST_INIT: begin
                // Seed the source; every insert write-back has already landed.
                n_idx = '0;
                if (src_in_range) begin
                    dist_we    = 1'b1;
                    dist_waddr = r_source_vertex[VW-1:0];
                    dist_wdata = '{fin: 1'b0, path_len: '0};
                end
                n_state = (n_eff == '0) ? sssp_pkg::ST_CLEAR : sssp_pkg::ST_SCAN;
            end
            sssp_pkg::ST_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end else if (sweep_done) begin
                    n_idx   = '0;
                    n_state = r_found ? sssp_pkg::ST_RELAX : sssp_pkg::ST_EMIT_RD;
                end
            end
            sssp_pkg::ST_RELAX: begin
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end else if (sweep_done) begin
                    n_idx   = '0;
                    n_state = sssp_pkg::ST_SCAN;
                end
            end
            sssp_pkg::ST_EMIT_RD: begin
                n_state = sssp_pkg::ST_EMIT_LD;
            end
            sssp_pkg::ST_EMIT_LD: begin
                n_state = sssp_pkg::ST_EMIT_WAIT;
            end
            sssp_pkg::ST_EMIT_WAIT: begin
                if (out_xfer) begin
                    if (r_o_last) begin
                        n_state = sssp_pkg::ST_CLEAR;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = sssp_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = sssp_pkg::ST_CLEAR;
            end
        endcase
    end

    // State register, configuration and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= sssp_pkg::ST_CLEAR;
            r_node_count    <= sssp_pkg::NODE_COUNT_RST;
            r_source_vertex <= '0;
            r_idx           <= '0;
            r_clr           <= '0;
            r_dvalid        <= '0;
            r_p_vld         <= 1'b0;
            r_e_vld         <= 1'b0;
            r_f_vld         <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sssp_pkg::REG_NODE_COUNT:    r_node_count    <= i_cfg_data;
                    sssp_pkg::REG_SOURCE_VERTEX: r_source_vertex <= i_cfg_data[VTX_W_M1:0];
                    default: ;
                endcase
            end

            // Advance the clearing pass; restart it on each entry.
            if ((n_state == sssp_pkg::ST_CLEAR) && (r_state != sssp_pkg::ST_CLEAR)) begin
                r_clr    <= '0;
                r_dvalid <= '0;
            end else begin
                if (r_state == sssp_pkg::ST_CLEAR) begin
                    r_clr <= r_clr + EAW'(1);
                end
                if (dist_we) begin
                    r_dvalid[dist_waddr] <= 1'b1;
                end
            end

            r_p_vld <= ((r_state == sssp_pkg::ST_SCAN) || (r_state == sssp_pkg::ST_RELAX))
                       && issue;
            r_e_vld <= in_xfer && (i_func == sssp_pkg::FUNC_ADD_EDGE) && edge_ok;
            r_f_vld <= e_wr;

            if (r_state == sssp_pkg::ST_EMIT_LD) begin
                r_o_valid <= 1'b1;
            end else if (out_xfer) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_p_idx  <= r_idx[VW-1:0];
        r_p_dv   <= r_dvalid[r_idx[VW-1:0]];
        r_e_addr <= add_addr;
        r_e_cost <= COST_BITS'(i_edge_cost);
        r_f_addr <= r_e_addr;
        r_f_data <= {1'b1, r_e_cost};

        if ((n_state == sssp_pkg::ST_SCAN) && (r_state != sssp_pkg::ST_SCAN)) begin
            r_best  <= sssp_pkg::UNREACHABLE;
            r_found <= 1'b0;
        end else if (scan_take) begin
            r_best  <= d_cur.path_len;
            r_u     <= r_p_idx;
            r_found <= 1'b1;
        end

        if (r_state == sssp_pkg::ST_EMIT_LD) begin
            r_o_vertex <= sssp_pkg::VTX_W'(r_idx[VW-1:0]);
            r_o_dist   <= d_cur.path_len;
            r_o_last   <= ((r_idx + CW'(1)) == n_eff);
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_vertex    = r_o_vertex;
    assign o_distance  = r_o_dist;
    assign o_last      = r_o_last;

endmodule

// ===== tb/tb_single_source_shortest_path.sv =====
// Testbench for the dense-graph shortest-path block: directed table, then random phases.
`timescale 1ns / 100ps

module tb_single_source_shortest_path;

    localparam int          MAX_N        = sssp_pkg::MAX_NODES_DEF;
    localparam int unsigned UNR          = sssp_pkg::UNREACHABLE;
    // Wait for the edge-store clearing pass over all MAX_N squared entries, plus margin.
    localparam int          CLEAR_CYCLES = MAX_N * MAX_N + 128;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          PLAN_LEN     = 26;

    typedef struct packed {
        logic [sssp_pkg::VTX_W-1:0]  vtx;
        logic [sssp_pkg::DIST_W-1:0] path_len;
        logic                        last;
    } t_dist_report;

    // Directed table: config rows write both registers, solve rows either run the
    // predictor or carry typed distances (source vertex / every other vertex).
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_EDGE,
        ROW_SOLVE,
        ROW_SOLVE_PINNED
    } t_plan_kind;

    typedef struct packed {
        t_plan_kind                  kind;
        logic [6:0]                  a;         // node count, or tail vertex
        logic [5:0]                  b;         // source vertex, or head vertex
        logic [15:0]                 cost;
        logic [sssp_pkg::DIST_W-1:0] pin_src;
        logic [sssp_pkg::DIST_W-1:0] pin_rest;
    } t_plan_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [sssp_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [sssp_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic                                i_func;
    logic [sssp_pkg::VTX_W-1:0]          i_from_vertex;
    logic [sssp_pkg::VTX_W-1:0]          i_to_vertex;
    logic [sssp_pkg::COST_W-1:0]         i_edge_cost;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [sssp_pkg::VTX_W-1:0]          o_vertex;
    logic [sssp_pkg::DIST_W-1:0]         o_distance;
    logic                                o_last;

    // Predictor state: adjacency store, distances, settled flags, register copies.
    bit                                  link_present [MAX_N*MAX_N];
    logic [15:0]                         link_cost    [MAX_N*MAX_N];
    int unsigned                         path_dist    [MAX_N];
    bit                                  settled      [MAX_N];
    int unsigned                         cfg_nodes;
    int unsigned                         cfg_src;

    t_dist_report                        dist_q [$];
    int unsigned                         err_count;
    int unsigned                         send_gap_pct;
    int unsigned                         recv_stall_pct;
    t_plan_row                           plan [PLAN_LEN];

    single_source_shortest_path DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .i_edge_cost   (i_edge_cost),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_vertex      (o_vertex),
        .o_distance    (o_distance),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #100_000_000;
        $display("tb_single_source_shortest_path: done, errors");
        $finish;
    end

    // Record an edge; keep the smaller weight when the pair is already present.
    function automatic void store_edge(input logic [5:0] from, input logic [5:0] to,
                                       input logic [15:0] cost);
        int idx;
        idx = int'(from) * MAX_N + int'(to);
        if (!link_present[idx] || cost < link_cost[idx]) begin
            link_cost[idx]    = cost;
            link_present[idx] = 1'b1;
        end
    endfunction

    // Array-based Dijkstra over the vertices in use; leaves the distances in
    // path_dist, clears the store and returns the number of vertices reported.
    function automatic int solve_graph();
        int          n, u, rnd, i;
        int unsigned best, sum;
        bit          found;
        n = (cfg_nodes > MAX_N) ? MAX_N : int'(cfg_nodes);
        for (i = 0; i < MAX_N; i++) begin
            path_dist[i] = UNR;
            settled[i]   = 1'b0;
        end
        if (cfg_src < n) path_dist[cfg_src] = 0;
        for (rnd = 0; rnd < n; rnd++) begin
            best  = UNR;
            found = 1'b0;
            u     = 0;
            // Pick the nearest unsettled vertex, lowest index on a tie.
            for (i = 0; i < n; i++) begin
                if (!settled[i] && path_dist[i] < best) begin
                    best  = path_dist[i];
                    u     = i;
                    found = 1'b1;
                end
            end
            if (!found) break;
            settled[u] = 1'b1;
            for (i = 0; i < n; i++) begin
                if (!settled[i] && link_present[u*MAX_N+i]) begin
                    sum = path_dist[u] + link_cost[u*MAX_N+i];
                    if (sum > UNR) sum = UNR;   // saturate: reads as unreachable
                    if (sum < path_dist[i]) path_dist[i] = sum;
                end
            end
        end
        for (i = 0; i < MAX_N*MAX_N; i++) link_present[i] = 1'b0;
        return n;
    endfunction

    // Drive one input transfer, with random sender gaps, and hold it until taken.
    // Then advance the predictor; a pinned solve queues the typed distances instead.
    task automatic send_item(input logic func, input logic [5:0] from,
                             input logic [5:0] to, input logic [15:0] cost,
                             input bit pinned = 1'b0, input int unsigned pin_src = 0,
                             input int unsigned pin_rest = 0);
        int           n, i;
        t_dist_report rep;
        while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_from_vertex <= from;
        i_to_vertex   <= to;
        i_edge_cost   <= cost;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (func == sssp_pkg::FUNC_ADD_EDGE) begin
            store_edge(from, to, cost);
        end else begin
            n = solve_graph();
            for (i = 0; i < n; i++) begin
                rep.vtx  = i[5:0];
                if (pinned) rep.path_len = (i == cfg_src) ? pin_src[21:0] : pin_rest[21:0];
                else        rep.path_len = path_dist[i][21:0];
                rep.last = (i == n - 1);
                dist_q.insert(dist_q.size(), rep);
            end
        end
    endtask

    // Drop valid, wait for every pending distance, then let the clearing pass finish.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (dist_q.size() != 0) @(posedge i_clk);
        repeat (CLEAR_CYCLES) @(posedge i_clk);
    endtask

    // Write node count, then source vertex, back to back.
    task automatic write_regs(input logic [6:0] nodes, input logic [5:0] src);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sssp_pkg::REG_NODE_COUNT;
        i_cfg_data  <= nodes;
        @(posedge i_clk);
        i_cfg_index <= sssp_pkg::REG_SOURCE_VERTEX;
        i_cfg_data  <= sssp_pkg::CFG_DATA_W'(src);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_nodes = 32'(nodes);
        cfg_src   = 32'(src);
    endtask

    // Receiver stall: fresh random decision every cycle at the current rate.
    always @(posedge i_clk) begin
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Compare each result transfer against the oldest expected distance.
    always @(posedge i_clk) begin : check_results
        t_dist_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dist_q.size() == 0) begin
                $display("%0t: unexpected result: vertex %0d distance %0d last %0b",
                         $time, o_vertex, o_distance, o_last);
                err_count++;
            end else begin
                want = dist_q.pop_front();
                if (o_vertex !== want.vtx) begin
                    $display("%0t: vertex mismatch: expected %0d, got %0d",
                             $time, want.vtx, o_vertex);
                    err_count++;
                end
                if (o_distance !== want.path_len) begin
                    $display("%0t: distance mismatch on vertex %0d: expected %0d, got %0d",
                             $time, want.vtx, want.path_len, o_distance);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch on vertex %0d: expected %0b, got %0b",
                             $time, want.vtx, want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned items_sent, phase, shape, pick, n, src, eff, edges, k, hops;
        logic [5:0]  from_v, to_v;
        logic [15:0] cost_v;
        t_plan_row   row;

        // Known values on every input from time zero; reset held at the start.
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = sssp_pkg::REG_NODE_COUNT;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_func         = sssp_pkg::FUNC_ADD_EDGE;
        i_from_vertex  = '0;
        i_to_vertex    = '0;
        i_edge_cost    = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        err_count      = 0;
        cfg_nodes      = 32'(sssp_pkg::NODE_COUNT_RST);
        cfg_src        = 0;
        for (int i = 0; i < MAX_N*MAX_N; i++) begin
            link_present[i] = 1'b0;
            link_cost[i]    = '0;
        end

        plan = '{
            // reset defaults: 64 vertices from vertex 0, empty store
            '{ROW_SOLVE_PINNED, 7'd0,   6'd0,  16'd0,      22'd0,  UNR[21:0]},
            // single vertex
            '{ROW_CFG,          7'd1,   6'd0,  16'd0,      22'd0,  22'd0},
            '{ROW_SOLVE_PINNED, 7'd0,   6'd0,  16'd0,      22'd0,  UNR[21:0]},
            // zero node count: no results, but the edge must still be cleared
            '{ROW_EDGE,         7'd0,   6'd1,  16'd5,      22'd0,  22'd0},
            '{ROW_CFG,          7'd0,   6'd0,  16'd0,      22'd0,  22'd0},
            '{ROW_SOLVE_PINNED, 7'd0,   6'd0,  16'd0,      UNR[21:0], UNR[21:0]},
            '{ROW_CFG,          7'd4,   6'd0,  16'd0,      22'd0,  22'd0},
            '{ROW_SOLVE_PINNED, 7'd0,   6'd0,  16'd0,      22'd0,  UNR[21:0]},
            // oversized count, top source, duplicates, self loop, zero and max cost
            '{ROW_CFG,          7'd127, 6'd63, 16'd0,      22'd0,  22'd0},
            '{ROW_EDGE,         7'd0,   6'd1,  16'd0,      22'd0,  22'd0},
            '{ROW_EDGE,         7'd63,  6'd62, 16'hFFFF,   22'd0,  22'd0},
            '{ROW_EDGE,         7'd63,  6'd62, 16'd7,      22'd0,  22'd0},
            '{ROW_EDGE,         7'd63,  6'd62, 16'd100,    22'd0,  22'd0},
            '{ROW_EDGE,         7'd62,  6'd62, 16'd3,      22'd0,  22'd0},
            '{ROW_EDGE,         7'd62,  6'd0,  16'd0,      22'd0,  22'd0},
            '{ROW_EDGE,         7'd0,   6'd63, 16'd1,      22'd0,  22'd0},
            '{ROW_SOLVE,        7'd0,   6'd0,  16'd0,      22'd0,  22'd0},
            // source outside the vertices in use, edge into an unused vertex
            '{ROW_CFG,          7'd5,   6'd10, 16'd0,      22'd0,  22'd0},
            '{ROW_EDGE,         7'd2,   6'd40, 16'd9,      22'd0,  22'd0},
            '{ROW_EDGE,         7'd10,  6'd0,  16'd1,      22'd0,  22'd0},
            '{ROW_SOLVE_PINNED, 7'd63,  6'd63, 16'hFFFF,   UNR[21:0], UNR[21:0]},
            // a shorter path through a zero-cost edge; solve fields carry junk
            '{ROW_CFG,          7'd6,   6'd2,  16'd0,      22'd0,  22'd0},
            '{ROW_EDGE,         7'd2,   6'd3,  16'hFFFF,   22'd0,  22'd0},
            '{ROW_EDGE,         7'd3,   6'd5,  16'hFFFF,   22'd0,  22'd0},
            '{ROW_EDGE,         7'd2,   6'd5,  16'd0,      22'd0,  22'd0},
            '{ROW_SOLVE,        7'd63,  6'd0,  16'hA5A5,   22'd0,  22'd0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: no idling on either side.
        for (int r = 0; r < PLAN_LEN; r++) begin
            row = plan[r];
            case (row.kind)
                ROW_CFG: begin
                    settle_block();
                    write_regs(row.a, row.b);
                end
                ROW_EDGE: begin
                    send_item(sssp_pkg::FUNC_ADD_EDGE, row.a[5:0], row.b, row.cost);
                end
                ROW_SOLVE: begin
                    send_item(sssp_pkg::FUNC_SOLVE, row.a[5:0], row.b, row.cost);
                end
                default: begin
                    send_item(sssp_pkg::FUNC_SOLVE, row.a[5:0], row.b, row.cost,
                              1'b1, row.pin_src, row.pin_rest);
                end
            endcase
        end

        // Random part: each phase sets the registers, loads a graph, then solves.
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            phase++;
            // Rotate through the idling patterns so gaps land on every solve stage.
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 69; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 69; end
                default: begin send_gap_pct = 30; recv_stall_pct = 30; end
            endcase

            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                // Long chain of near-max weights: far end must saturate.
                n   = 64;
                src = 0;
            end else begin
                pick = $urandom_range(0, 19);
                if (pick == 0)      n = 64;
                else if (pick == 1) n = $urandom_range(65, 127);
                else if (pick == 2) n = 0;
                else if (pick < 6)  n = $urandom_range(13, 24);
                else                n = $urandom_range(1, 12);
                eff = (n > MAX_N) ? MAX_N : n;
                if (eff == 0 || $urandom_range(0, 7) == 0) src = $urandom_range(0, 63);
                else                                        src = $urandom_range(0, eff - 1);
            end
            eff = (n > MAX_N) ? MAX_N : n;

            settle_block();
            write_regs(n[6:0], src[5:0]);

            if (shape == 0) begin
                hops = $urandom_range(33, 45);
                for (k = 0; k < hops; k++) begin
                    cost_v = 16'hFFFF - 16'($urandom_range(0, 2));
                    send_item(sssp_pkg::FUNC_ADD_EDGE, k[5:0], 6'(k + 1), cost_v);
                end
                items_sent += hops;
            end else begin
                edges  = $urandom_range(3, 20);
                from_v = '0;
                to_v   = '0;
                for (k = 0; k < edges; k++) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0 || eff == 0) begin
                        // noise: anywhere in the store, used vertices or not
                        from_v = 6'($urandom_range(0, 63));
                        to_v   = 6'($urandom_range(0, 63));
                    end else if (pick != 1 || k == 0) begin
                        from_v = 6'($urandom_range(0, eff - 1));
                        to_v   = 6'($urandom_range(0, eff - 1));
                    end
                    // otherwise repeat the previous pair with a new weight
                    pick = $urandom_range(0, 7);
                    if (pick == 0)      cost_v = 16'd0;
                    else if (pick == 1) cost_v = 16'hFFFF;
                    else if (pick < 4)  cost_v = 16'($urandom_range(0, 15));
                    else                cost_v = 16'($urandom_range(0, 65535));
                    send_item(sssp_pkg::FUNC_ADD_EDGE, from_v, to_v, cost_v);
                end
                items_sent += edges;
            end

            send_item(sssp_pkg::FUNC_SOLVE, 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
            items_sent++;

            // Hold the sender until the solve has fully drained, then solve the
            // freshly cleared store.
            if (phase == 1 || $urandom_range(0, 3) == 0) begin
                if (dist_q.size() != 0) begin
                    i_in_valid <= 1'b0;
                    while (dist_q.size() != 0) @(posedge i_clk);
                end
                send_item(sssp_pkg::FUNC_SOLVE, 6'($urandom_range(0, 63)),
                          6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
                items_sent++;
            end
        end

        // Drain, then allow a full clearing pass for any stray result to show up.
        settle_block();
        if (err_count == 0) begin
            $display("tb_single_source_shortest_path: done, clean");
        end else begin
            $display("tb_single_source_shortest_path: done, errors");
        end
        $finish;
    end

endmodule

// ===== single_source_shortest_path.f =====
rtl/sssp_pkg.sv
rtl/sssp_ram.sv
rtl/single_source_shortest_path.sv
tb/tb_single_source_shortest_path.sv
